FILE: src/qemm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qemm_pkg
// Shared widths, register indexes, reset values and fixed-point helpers for
// the quad element mass matrix block.
// ---------------------------------------------------------------------------
package qemm_pkg;

   localparam int NODE_W  = 17;   // one-based node number
   localparam int HNODE_W = 16;   // zero-based node number as held
   localparam int COORD_W = 32;   // Q16.16 coordinate
   localparam int IDX_W   = 17;   // global row / column index
   localparam int VAL_W   = 48;   // mass value, 24 fraction bits
   localparam int CSR_W   = 64;   // widest register
   localparam int CSR_A_W = 3;    // register index
   localparam int ENTRIES = 16;   // local matrix entries
   localparam int NPE     = 4;    // nodes per element

   localparam int MULA_W  = 33;   // shared multiplier operand a
   localparam int MULB_W  = 32;   // shared multiplier operand b
   localparam int PROD_W  = MULA_W + MULB_W;
   localparam int ACC_W   = 52;   // Jacobian accumulator

   // register indexes on the csr port
   typedef enum logic [CSR_A_W-1:0] {
      CSR_SHAPE00 = 3'd0,
      CSR_SHAPE01 = 3'd1,
      CSR_SHAPE10 = 3'd2,
      CSR_SHAPE11 = 3'd3,
      CSR_GPOINTS = 3'd4,
      CSR_GWEIGHTS = 3'd5,
      CSR_NCOUNT  = 3'd6
   } csr_index_type;

   localparam logic [31:0]       GPOINTS_RST  = 32'h24F3_DB0D;
   localparam logic [31:0]       GWEIGHTS_RST = 32'h4000_4000;
   localparam logic [IDX_W-1:0]  NCOUNT_RST   = 17'd65536;

   localparam logic signed [17:0] ONE_Q14 = 18'sd16384;

   localparam logic signed [PROD_W-1:0] MAX48 = PROD_W'(64'sd140737488355327);
   localparam logic signed [PROD_W-1:0] MIN48 = -PROD_W'(64'sd140737488355328);
   localparam logic signed [36:0]       JMAX  = 37'sd2147483647;

   // saturate a wide signed value to 48 bits
   function automatic logic signed [VAL_W-1:0] sat48(input logic signed [PROD_W-1:0] v);
      logic signed [VAL_W-1:0] r;
      if (v > MAX48)
         r = MAX48[VAL_W-1:0];
      else if (v < MIN48)
         r = MIN48[VAL_W-1:0];
      else
         r = v[VAL_W-1:0];
      return r;
   endfunction

   // Jacobian entry: round to 16 fraction bits, saturate symmetric 32 bits
   function automatic logic signed [31:0] round_jac(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W:0] t;
      logic signed [36:0]    r;
      logic signed [31:0]    o;
      t = {v[ACC_W-1], v} + (ACC_W+1)'(32768);
      r = 37'(t >>> 16);
      if (r > JMAX)
         o = JMAX[31:0];
      else if (r < -JMAX)
         o = -JMAX[31:0];
      else
         o = r[31:0];
      return o;
   endfunction

endpackage

FILE: src/qemm_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qemm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module qemm_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/quad_element_mass_matrix.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quad_element_mass_matrix
// Four-node bilinear quad mass matrix over a 2x2 Gauss rule, fixed point.
// ---------------------------------------------------------------------------
// Usage:
//  - req_* takes one element word: four one-based node numbers and the
//    Q16.16 x/y coordinates of the four nodes. req_ready is high only
//    while the block is idle.
//  - rsp_* gives 32 words per element (row, column, value), row-major over
//    the local 4x4 matrix, each x entry followed by its y entry offset by
//    node_count. rsp_last_of_element marks the 32nd word.
//  - csr_* writes the shape values, Gauss points, weights and node count.
//    Write only while idle.
// Sequence per Gauss point: the Jacobian products, rounding, the determinant,
// the volume weight and, per matrix entry, a read-modify-write of the local
// mass RAM. Emission then does one RAM read per entry pair and gives the
// pair as two words.
// The Jacobian, determinant, volume weight and entry products go through one
// shared 33x32 multiplier; the weight and shape coefficient products do not.
// The next element is accepted as soon as the last word is loaded.
// Reset clears control and restores register defaults; a stalled rsp word
// holds and the sequencer waits on it.
// ---------------------------------------------------------------------------
module quad_element_mass_matrix (
   input  logic                                  clock,
   input  logic                                  reset,
   // element input
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [qemm_pkg::NODE_W-1:0]           req_node_first,
   input  logic [qemm_pkg::NODE_W-1:0]           req_node_second,
   input  logic [qemm_pkg::NODE_W-1:0]           req_node_third,
   input  logic [qemm_pkg::NODE_W-1:0]           req_node_fourth,
   input  logic signed [qemm_pkg::COORD_W-1:0]   req_x_first,
   input  logic signed [qemm_pkg::COORD_W-1:0]   req_x_second,
   input  logic signed [qemm_pkg::COORD_W-1:0]   req_x_third,
   input  logic signed [qemm_pkg::COORD_W-1:0]   req_x_fourth,
   input  logic signed [qemm_pkg::COORD_W-1:0]   req_y_first,
   input  logic signed [qemm_pkg::COORD_W-1:0]   req_y_second,
   input  logic signed [qemm_pkg::COORD_W-1:0]   req_y_third,
   input  logic signed [qemm_pkg::COORD_W-1:0]   req_y_fourth,
   // triplet output
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [qemm_pkg::IDX_W-1:0]            rsp_row_index,
   output logic [qemm_pkg::IDX_W-1:0]            rsp_col_index,
   output logic signed [qemm_pkg::VAL_W-1:0]     rsp_mass_value,
   output logic                                  rsp_last_of_element,
   // register writes
   input  logic                                  csr_we,
   input  logic [qemm_pkg::CSR_A_W-1:0]          csr_index,
   input  logic [qemm_pkg::CSR_W-1:0]            csr_wdata
);

   import qemm_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_JAC  = 8'b0000_0010,
      S_JRND = 8'b0000_0100,
      S_DET  = 8'b0000_1000,
      S_RND  = 8'b0001_0000,
      S_TERM = 8'b0010_0000,
      S_ERD  = 8'b0100_0000,
      S_EOUT = 8'b1000_0000
   } state_type;

   localparam int ADDR_W = $clog2(ENTRIES);

   // configuration
   logic [CSR_W-1:0]   shape_ff [4];
   logic [31:0]        gpts_ff;
   logic [31:0]        gwts_ff;
   logic [IDX_W-1:0]   ncount_ff;

   // element operands
   logic [HNODE_W-1:0]        held_ff [NPE];
   logic [HNODE_W-1:0]        rowq_ff [NPE];
   logic signed [COORD_W-1:0] xs_ff [NPE];
   logic signed [COORD_W-1:0] ys_ff [NPE];

   // sequencer
   state_type    state_ff, state_in;
   logic [4:0]   step_ff, step_in;
   logic [1:0]   pt_ff, pt_in;
   logic [3:0]   ab_ff, ab_in;
   logic [4:0]   emit_ff, emit_in;

   // datapath
   logic signed [ACC_W-1:0]  acc_ff [4];
   logic signed [31:0]       jac_ff [4];
   logic signed [PROD_W-1:0] prod_ff, p1_ff, tsh_ff;
   logic signed [MULA_W-1:0] mul_a;
   logic signed [MULB_W-1:0] mul_b;
   logic signed [VAL_W-1:0]  det24_ff, dv_ff, res_ff, opa;
   logic signed [31:0]       coef_ff, coef_in;

   // output word
   logic                     rsp_valid_ff;
   logic [IDX_W-1:0]         row_ff, col_ff;
   logic signed [VAL_W-1:0]  val_ff;
   logic                     last_ff;

   // local mass RAM
   logic                     ram_we, ram_re;
   logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
   logic [VAL_W-1:0]         ram_wdata, ram_rdata;

   logic signed [15:0] xi, eta, w_i, w_j, nv_a, nv_b;
   logic signed [17:0] one_m_eta, one_p_eta, one_m_xi, one_p_xi;
   logic signed [17:0] dxi, deta, deriv;
   logic signed [COORD_W-1:0] coord;
   logic [3:0]  pidx;
   logic [1:0]  kk;
   logic        accept, load_out;
   logic signed [VAL_W-1:0]  base;
   logic signed [PROD_W-1:0] tsum;
   logic [CSR_W-1:0] sreg;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            shape_ff[i] <= '0;
         end
         gpts_ff   <= GPOINTS_RST;
         gwts_ff   <= GWEIGHTS_RST;
         ncount_ff <= NCOUNT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SHAPE00:  shape_ff[0] <= csr_wdata;
            CSR_SHAPE01:  shape_ff[1] <= csr_wdata;
            CSR_SHAPE10:  shape_ff[2] <= csr_wdata;
            CSR_SHAPE11:  shape_ff[3] <= csr_wdata;
            CSR_GPOINTS:  gpts_ff     <= csr_wdata[31:0];
            CSR_GWEIGHTS: gwts_ff     <= csr_wdata[31:0];
            CSR_NCOUNT:   ncount_ff   <= csr_wdata[IDX_W-1:0];
            default: ;
         endcase
      end
   end

   // Gauss point operands: xi from point index i, eta from j
   assign xi  = pt_ff[1] ? gpts_ff[31:16] : gpts_ff[15:0];
   assign eta = pt_ff[0] ? gpts_ff[31:16] : gpts_ff[15:0];
   assign w_i = pt_ff[1] ? gwts_ff[31:16] : gwts_ff[15:0];
   assign w_j = pt_ff[0] ? gwts_ff[31:16] : gwts_ff[15:0];
   assign one_m_eta = ONE_Q14 - 18'(eta);
   assign one_p_eta = ONE_Q14 + 18'(eta);
   assign one_m_xi  = ONE_Q14 - 18'(xi);
   assign one_p_xi  = ONE_Q14 + 18'(xi);

   // shape values of the current point for entry (a,b)
   assign sreg = shape_ff[pt_ff];
   assign nv_a = sreg[{ab_ff[3:2], 4'b0000} +: 16];
   assign nv_b = sreg[{ab_ff[1:0], 4'b0000} +: 16];

   // derivative and coordinate for Jacobian product number step
   assign kk = step_ff[1:0];
   always_comb begin
      case (kk)
         2'd0:    begin dxi = -one_m_eta; deta = -one_m_xi; end
         2'd1:    begin dxi =  one_m_eta; deta = -one_p_xi; end
         2'd2:    begin dxi =  one_p_eta; deta =  one_p_xi; end
         default: begin dxi = -one_p_eta; deta =  one_m_xi; end
      endcase
      deriv = step_ff[3] ? deta : dxi;
      coord = step_ff[2] ? ys_ff[kk] : xs_ff[kk];
   end

   assign opa = (state_ff == S_TERM) ? dv_ff : det24_ff;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_JAC: begin
            mul_a = MULA_W'(deriv);
            mul_b = coord;
         end
         S_DET: begin
            if (step_ff[0]) begin
               mul_a = MULA_W'(jac_ff[1]);
               mul_b = jac_ff[2];
            end else begin
               mul_a = MULA_W'(jac_ff[0]);
               mul_b = jac_ff[3];
            end
         end
         S_RND, S_TERM: begin
            if (step_ff == 5'd1) begin
               mul_a = MULA_W'($signed({1'b0, opa[23:0]}));
            end else begin
               mul_a = MULA_W'($signed(opa[VAL_W-1:24]));
            end
            mul_b = coef_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      coef_in = coef_ff;
      if (step_ff == 5'd0) begin
         if (state_ff == S_RND)
            coef_in = 32'(w_i * w_j);
         else if (state_ff == S_TERM)
            coef_in = 32'(nv_a * nv_b);
      end
   end

   assign pidx = 4'(step_ff - 5'd1);
   assign tsum = prod_ff + tsh_ff;
   assign base = (pt_ff == 2'd0) ? '0 : $signed(ram_rdata);
   assign load_out = (state_ff == S_EOUT) && (!rsp_valid_ff || rsp_ready);

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      coef_ff <= coef_in;
      if (accept) begin
         held_ff[0] <= 16'(req_node_first  - 17'd1);
         held_ff[1] <= 16'(req_node_second - 17'd1);
         held_ff[2] <= 16'(req_node_third  - 17'd1);
         held_ff[3] <= 16'(req_node_fourth - 17'd1);
         rowq_ff[0] <= 16'(req_node_first  - 17'd1);
         rowq_ff[1] <= 16'(req_node_second - 17'd1);
         rowq_ff[2] <= 16'(req_node_third  - 17'd1);
         rowq_ff[3] <= 16'(req_node_fourth - 17'd1);
         xs_ff[0] <= req_x_first;  xs_ff[1] <= req_x_second;
         xs_ff[2] <= req_x_third;  xs_ff[3] <= req_x_fourth;
         ys_ff[0] <= req_y_first;  ys_ff[1] <= req_y_second;
         ys_ff[2] <= req_y_third;  ys_ff[3] <= req_y_fourth;
      end
      // Jacobian sums, one product per cycle, each added in the cycle after its issue
      if (state_ff == S_JAC && step_ff != 5'd0) begin
         acc_ff[pidx[3:2]] <= ((pidx[1:0] == 2'd0) ? '0 : acc_ff[pidx[3:2]])
                              + prod_ff[ACC_W-1:0];
      end
      if (state_ff == S_JRND) begin
         for (int e = 0; e < 4; e++) begin
            jac_ff[e] <= round_jac(acc_ff[e]);
         end
      end
      // determinant, rounded to 24 fraction bits
      if (state_ff == S_DET) begin
         if (step_ff == 5'd1)
            p1_ff <= prod_ff;
         if (step_ff == 5'd2)
            det24_ff <= sat48((p1_ff - prod_ff + PROD_W'(128)) >>> 8);
      end
      // round(opa * coef / 2^28) in two partial products
      if (state_ff == S_RND || state_ff == S_TERM) begin
         if (step_ff == 5'd2)
            tsh_ff <= (prod_ff + PROD_W'(134217728)) >>> 24;
         if (step_ff == 5'd3)
            res_ff <= sat48(tsum >>> 4);
      end
      if (state_ff == S_RND && step_ff == 5'd4)
         dv_ff <= res_ff;
      // output word
      if (load_out) begin
         row_ff  <= IDX_W'(rowq_ff[0]) + (emit_ff[0] ? ncount_ff : '0);
         col_ff  <= IDX_W'(held_ff[emit_ff[2:1]]) + (emit_ff[0] ? ncount_ff : '0);
         val_ff  <= $signed(ram_rdata);
         last_ff <= (emit_ff == 5'd31);
         if (emit_ff[2:0] == 3'd7) begin
            for (int r = 0; r < NPE - 1; r++) begin
               rowq_ff[r] <= rowq_ff[r + 1];
            end
            rowq_ff[NPE-1] <= rowq_ff[0];
         end
      end
   end

   // local mass RAM port control
   always_comb begin
      ram_re    = 1'b0;
      ram_raddr = ab_ff;
      ram_we    = 1'b0;
      ram_waddr = ab_ff;
      ram_wdata = VAL_W'(sat48(PROD_W'(base) + PROD_W'(res_ff)));
      if (state_ff == S_TERM) begin
         ram_re = (step_ff == 5'd0);
         ram_we = (step_ff == 5'd4);
      end else if (state_ff == S_ERD) begin
         ram_re    = 1'b1;
         ram_raddr = emit_ff[4:1];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      pt_in    = pt_ff;
      ab_in    = ab_ff;
      emit_in  = emit_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_JAC;
               step_in  = '0;
               pt_in    = '0;
            end
         end
         S_JAC: begin
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd16) begin
               state_in = S_JRND;
               step_in  = '0;
            end
         end
         S_JRND: begin
            state_in = S_DET;
            step_in  = '0;
         end
         S_DET: begin
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd2) begin
               state_in = S_RND;
               step_in  = '0;
            end
         end
         S_RND: begin
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd4) begin
               state_in = S_TERM;
               step_in  = '0;
               ab_in    = '0;
            end
         end
         S_TERM: begin
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd4) begin
               step_in = '0;
               ab_in   = ab_ff + 4'd1;
               if (ab_ff == 4'd15) begin
                  pt_in = pt_ff + 2'd1;
                  if (pt_ff == 2'd3) begin
                     state_in = S_ERD;
                     emit_in  = '0;
                  end else begin
                     state_in = S_JAC;
                  end
               end
            end
         end
         S_ERD: begin
            state_in = S_EOUT;
         end
         S_EOUT: begin
            if (load_out) begin
               emit_in = emit_ff + 5'd1;
               if (emit_ff == 5'd31)
                  state_in = S_IDLE;
               else if (emit_ff[0])
                  state_in = S_ERD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         pt_ff        <= '0;
         ab_ff        <= '0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         pt_ff    <= pt_in;
         ab_ff    <= ab_in;
         emit_ff  <= emit_in;
         if (load_out)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   qemm_ram #(
      .WIDTH (VAL_W),
      .DEPTH (ENTRIES)
   ) u_mass_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_row_index       = row_ff;
   assign rsp_col_index       = col_ff;
   assign rsp_mass_value      = val_ff;
   assign rsp_last_of_element = last_ff;

endmodule

FILE: src/qemm_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qemm_checker
// Port-level checks on the quad element mass matrix block.
// ---------------------------------------------------------------------------
module qemm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [qemm_pkg::IDX_W-1:0]         rsp_row_index,
   input logic [qemm_pkg::IDX_W-1:0]         rsp_col_index,
   input logic signed [qemm_pkg::VAL_W-1:0]  rsp_mass_value,
   input logic                               rsp_last_of_element
);

   // no word is shown right out of reset
   a_rst_quiet: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("rsp word valid right after reset");

   // input ready drops in the cycle after an element is accepted
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after element accept");

   // a stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready == 1'b0 |=> rsp_valid && $stable(rsp_row_index)
         && $stable(rsp_col_index) && $stable(rsp_mass_value)
         && $stable(rsp_last_of_element))
      else $error("stalled rsp word changed");

   // the last word of an element is never followed right away by another last word
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_of_element |=> !rsp_valid || !rsp_last_of_element)
      else $error("two last words in a row");

endmodule

bind quad_element_mass_matrix qemm_checker u_checker (.*);
